>>> design/owvcs_pkg.sv
// Shared types and constants for the one-wire voice command sender.
// Holds the request/result structs, request kinds, register indexes and timing constants.
// No dependencies.
package owvcs_pkg;

  // Queue sizing
  localparam int MAX_SEGMENTS = 32;
  localparam int QCNT_W       = 6;
  localparam int SEG_IDX_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [QCNT_W-1:0] MAX_SEG_C = QCNT_W'(MAX_SEGMENTS);

  // Protocol bytes
  localparam logic [7:0] FRAME_HEAD_BYTE = 8'hFE;
  localparam logic [7:0] SEG_CMD_BYTE    = 8'hF3;

  // Pulse timing, in ticks
  localparam logic [8:0]  START_TICKS    = 9'd27;
  localparam logic [8:0]  BYTE_GAP_TICKS = 9'd10;
  localparam logic [8:0]  FRAME_GAP_TICKS = 9'd333;
  localparam logic [8:0]  LONG_TICKS     = 9'd3;
  localparam logic [8:0]  SHORT_TICKS    = 9'd1;
  localparam logic [10:0] PLAY_END_TICKS = 11'd1500;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_TICK      = 2'd0,
    KIND_QUEUE     = 2'd1,
    KIND_START_FRM = 2'd2,
    KIND_START_RAW = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOICE_ENABLE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LANGUAGE_OFFSET = 1'd1;
  localparam int CFG_DATA_W = 8;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] segment;
    logic       use_language;
    logic       quiet_context;
    logic       busy_pin;
  } in_item_t;

  typedef struct packed {
    logic data_line;
    logic sending;
    logic play_end;
    logic accepted;
  } out_item_t;

endpackage

>>> design/one_wire_voice_command_sender.sv
// One-wire voice command sender: top level, request decode, transmitter and result register.
// Depends on owvcs_pkg.
//
// Each request (a tick, a segment push, a frame start or a raw command start) is
// handled in the cycle it is accepted: all state updates in one pass of logic, and
// the result is captured in an output register at the end of that cycle. The block takes one
// request per clock while the result side keeps up; the output register is the
// only place a request waits, so in_stall is high only while a result is held by
// out_stall. Line timing counts in ticks (kind 0 requests), not clocks: 27-tick
// start pulse, 4 ticks per bit, 10-tick byte gap and 333-tick gap after a frame.
// The segment queue holds 32 entries; reading an entry never pushed is undefined.
module one_wire_voice_command_sender (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  owvcs_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output owvcs_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [owvcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [owvcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_DATA  = 3'd2,
    PH_END   = 3'd3,
    PH_NEXT  = 3'd4
  } phase_t;

  // Configuration
  logic       voice_en_r;
  logic [7:0] lang_ofs_r;

  // Segment queue (no reset: entries are read only after being pushed)
  logic [7:0] seg_store_r [owvcs_pkg::MAX_SEGMENTS];

  // Sender state
  logic [owvcs_pkg::QCNT_W-1:0] q_cnt_r, q_cnt_nxt;
  logic [owvcs_pkg::QCNT_W-1:0] frm_segs_r, frm_segs_nxt;
  logic        raw_mode_r, raw_mode_nxt;
  logic [7:0]  raw_byte_r, raw_byte_nxt;
  logic        lang_app_r, lang_app_nxt;
  phase_t      phase_r, phase_nxt;
  logic [8:0]  tick_r, tick_nxt;
  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [6:0]  byte_idx_r, byte_idx_nxt;
  logic        line_r, line_nxt;
  logic [10:0] end_cnt_r, end_cnt_nxt;
  logic        end_flag_r, end_flag_nxt;

  // Result register
  logic                 out_valid_r;
  owvcs_pkg::out_item_t out_data_r;
  owvcs_pkg::out_item_t res_nxt;

  logic in_acc;
  logic push_we;

  // Helper terms
  logic                         blocked;
  logic                         is_sending;
  logic [8:0]                   tick_dec;
  logic [3:0]                   bit_idx_inc;
  logic [6:0]                   byte_idx_inc;
  logic [6:0]                   total_bytes;
  logic [owvcs_pkg::QCNT_W-1:0] seg_k;
  logic [7:0]                   seg_val;
  logic [7:0]                   frame_byte;

  // Handshake: the output register is the only place a request can wait
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign blocked    = !voice_en_r && in_data.quiet_context;
  assign is_sending = (phase_r == PH_START) || (phase_r == PH_DATA) ||
                      (phase_r == PH_END)   || (phase_r == PH_NEXT);
  assign push_we    = in_acc && (in_data.kind == owvcs_pkg::KIND_QUEUE) &&
                      !is_sending && (q_cnt_r < owvcs_pkg::MAX_SEG_C);

  // Tick arithmetic
  assign tick_dec     = (tick_r != 9'd0) ? (tick_r - 9'd1) : 9'd0;
  assign bit_idx_inc  = bit_idx_r + 4'd1;
  assign byte_idx_inc = byte_idx_r + 7'd1;
  assign total_bytes  = raw_mode_r ? 7'd1 : {frm_segs_r, 1'b1};

  // Byte to send at the current byte position
  assign seg_k = byte_idx_r[6:1] - 6'd1;
  always_comb begin
    seg_val = 8'd0;
    if (seg_k < owvcs_pkg::MAX_SEG_C) begin
      seg_val = seg_store_r[seg_k[owvcs_pkg::SEG_IDX_W-1:0]];
    end
    if (lang_app_r) begin
      seg_val = seg_val + lang_ofs_r;
    end
  end

  always_comb begin
    if (raw_mode_r) begin
      frame_byte = raw_byte_r;
    end else if (byte_idx_r == 7'd0) begin
      frame_byte = owvcs_pkg::FRAME_HEAD_BYTE;
    end else if (byte_idx_r[0]) begin
      frame_byte = owvcs_pkg::SEG_CMD_BYTE;
    end else begin
      frame_byte = seg_val;
    end
  end

  // Next state for one request
  always_comb begin
    q_cnt_nxt    = q_cnt_r;
    frm_segs_nxt = frm_segs_r;
    raw_mode_nxt = raw_mode_r;
    raw_byte_nxt = raw_byte_r;
    lang_app_nxt = lang_app_r;
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    bit_idx_nxt  = bit_idx_r;
    shift_nxt    = shift_r;
    byte_idx_nxt = byte_idx_r;
    line_nxt     = line_r;
    end_cnt_nxt  = end_cnt_r;
    end_flag_nxt = end_flag_r;
    res_nxt.accepted = 1'b0;

    case (in_data.kind)
      owvcs_pkg::KIND_TICK: begin
        tick_nxt = tick_dec;
        if (tick_dec == 9'd0) begin
          case (phase_r)
            PH_START: begin
              line_nxt  = 1'b0;
              tick_nxt  = owvcs_pkg::START_TICKS;
              phase_nxt = PH_DATA;
              shift_nxt = frame_byte;
            end
            PH_DATA: begin
              if (!line_r) begin
                line_nxt = 1'b1;
                tick_nxt = shift_r[0] ? owvcs_pkg::LONG_TICKS : owvcs_pkg::SHORT_TICKS;
              end else begin
                line_nxt    = 1'b0;
                tick_nxt    = shift_r[0] ? owvcs_pkg::SHORT_TICKS : owvcs_pkg::LONG_TICKS;
                shift_nxt   = {1'b0, shift_r[7:1]};
                bit_idx_nxt = bit_idx_inc;
                if (bit_idx_inc >= 4'd8) begin
                  phase_nxt = PH_END;
                end
              end
            end
            PH_END: begin
              line_nxt     = 1'b1;
              byte_idx_nxt = byte_idx_inc;
              if (byte_idx_inc < total_bytes) begin
                phase_nxt = PH_NEXT;
                tick_nxt  = owvcs_pkg::BYTE_GAP_TICKS;
              end else begin
                phase_nxt = PH_IDLE;
                tick_nxt  = owvcs_pkg::FRAME_GAP_TICKS;
              end
            end
            PH_NEXT: begin
              phase_nxt   = PH_START;
              bit_idx_nxt = 4'd0;
            end
            default: begin
              // Idle: watch the busy pin for end of playback
              line_nxt = 1'b1;
              if (in_data.busy_pin) begin
                if (end_cnt_r < owvcs_pkg::PLAY_END_TICKS) begin
                  end_cnt_nxt = end_cnt_r + 11'd1;
                end else begin
                  end_flag_nxt = 1'b1;
                end
              end else begin
                end_cnt_nxt  = 11'd0;
                end_flag_nxt = 1'b0;
              end
            end
          endcase
        end
      end
      owvcs_pkg::KIND_QUEUE: begin
        if (!is_sending && (q_cnt_r < owvcs_pkg::MAX_SEG_C)) begin
          q_cnt_nxt        = q_cnt_r + 6'd1;
          res_nxt.accepted = 1'b1;
        end
      end
      default: begin
        // Frame or raw start
        if (!blocked) begin
          if (in_data.kind == owvcs_pkg::KIND_START_FRM) begin
            raw_mode_nxt = 1'b0;
            frm_segs_nxt = q_cnt_r;
            q_cnt_nxt    = '0;
            lang_app_nxt = in_data.use_language;
          end else begin
            raw_mode_nxt = 1'b1;
            raw_byte_nxt = in_data.segment;
          end
          byte_idx_nxt     = 7'd0;
          bit_idx_nxt      = 4'd0;
          phase_nxt        = PH_START;
          end_cnt_nxt      = 11'd0;
          end_flag_nxt     = 1'b0;
          res_nxt.accepted = 1'b1;
        end
      end
    endcase

    res_nxt.data_line = line_nxt;
    res_nxt.sending   = (phase_nxt == PH_START) || (phase_nxt == PH_DATA) ||
                        (phase_nxt == PH_END)   || (phase_nxt == PH_NEXT);
    res_nxt.play_end  = end_flag_nxt;
  end

  // Segment queue write
  always_ff @(posedge clk) begin
    if (push_we) begin
      seg_store_r[q_cnt_r[owvcs_pkg::SEG_IDX_W-1:0]] <= in_data.segment;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res_nxt;
    end
  end

  // Control state, configuration and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_en_r  <= 1'b1;
      lang_ofs_r  <= 8'd0;
      q_cnt_r     <= '0;
      frm_segs_r  <= '0;
      raw_mode_r  <= 1'b0;
      raw_byte_r  <= 8'd0;
      lang_app_r  <= 1'b0;
      phase_r     <= PH_IDLE;
      tick_r      <= 9'd0;
      bit_idx_r   <= 4'd0;
      shift_r     <= 8'd0;
      byte_idx_r  <= 7'd0;
      line_r      <= 1'b1;
      end_cnt_r   <= 11'd0;
      end_flag_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          owvcs_pkg::CFG_VOICE_ENABLE:    voice_en_r <= cfg_wdata[0];
          owvcs_pkg::CFG_LANGUAGE_OFFSET: lang_ofs_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        q_cnt_r    <= q_cnt_nxt;
        frm_segs_r <= frm_segs_nxt;
        raw_mode_r <= raw_mode_nxt;
        raw_byte_r <= raw_byte_nxt;
        lang_app_r <= lang_app_nxt;
        phase_r    <= phase_nxt;
        tick_r     <= tick_nxt;
        bit_idx_r  <= bit_idx_nxt;
        shift_r    <= shift_nxt;
        byte_idx_r <= byte_idx_nxt;
        line_r     <= line_nxt;
        end_cnt_r  <= end_cnt_nxt;
        end_flag_r <= end_flag_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> design/owvcs_checker.sv
// Port-level checker for the one-wire voice command sender, bound to the top level.
// Depends on owvcs_pkg and one_wire_voice_command_sender.
module owvcs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input owvcs_pkg::in_item_t              in_data,
  input logic                             out_valid,
  input logic                             out_stall,
  input owvcs_pkg::out_item_t             out_data
);

  logic in_req;
  assign in_req = in_valid && !in_stall;

  // A held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The input side waits only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no result waiting");

  // A tick never reports an accepted request
  a_tick_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_req && in_data.kind == owvcs_pkg::KIND_TICK |=> out_valid && !out_data.accepted)
    else $error("tick reported as accepted");

  // A push takes effect only while idle
  a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_req && in_data.kind == owvcs_pkg::KIND_QUEUE |=>
      out_valid && !(out_data.accepted && out_data.sending))
    else $error("push accepted while sending");

  // An accepted start begins sending and clears play-end
  a_start_sends: assert property (@(posedge clk) disable iff (!rst_n)
    in_req && (in_data.kind == owvcs_pkg::KIND_START_FRM ||
               in_data.kind == owvcs_pkg::KIND_START_RAW) |=>
      out_valid && (!out_data.accepted || (out_data.sending && !out_data.play_end)))
    else $error("accepted start did not begin sending");

endmodule

bind one_wire_voice_command_sender owvcs_checker u_owvcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
